[rtl/core/u8d_pkg.sv]
// ---------------------------------------------------------------------------
// u8d_pkg: UTF-8 stream decoder shared definitions
// Transaction payload types, queue entry type and the lead byte classifier.
// ---------------------------------------------------------------------------
package u8d_pkg;

    localparam int          QUEUE_DEPTH   = 2;
    localparam logic [31:0] INVALID_RESET = 32'h0000_FFFD;

    // sequence length codes given by a lead byte
    localparam logic [2:0] LEN_BAD  = 3'd0;
    localparam logic [2:0] LEN_ONE  = 3'd1;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic [2:0]  bytes_used;
        logic        is_invalid;
        logic        run_last;
    } out_t;

    // classified byte as it sits in the front queue
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
        logic [2:0] seq_len;
    } q_item_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] held;
    } back_status_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] res;
        case (b) inside
            [8'h00:8'h7F]: res = LEN_ONE;
            [8'hC0:8'hDF]: res = LEN_TWO;
            [8'hE0:8'hEF]: res = LEN_THREE;
            [8'hF0:8'hF7]: res = LEN_FOUR;
            default:       res = LEN_BAD;
        endcase
        return res;
    endfunction

endpackage

[rtl/core/u8d_front.sv]
// ---------------------------------------------------------------------------
// u8d_front: input side of the UTF-8 decoder
// Accepts bytes, tags each with the sequence length it would give as a lead,
// and queues them for the decode stage.
// ---------------------------------------------------------------------------
module u8d_front #(
    parameter int QDEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  u8d_pkg::in_t      in_item,
    output logic              q_valid,
    input  logic              q_pop,
    output u8d_pkg::q_item_t  q_item
);
    import u8d_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    q_item_t         mem_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            wr_en, rd_en;

    assign full    = (count_reg == CW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= '{byte_in:      in_item.byte_in,
                                     end_of_input: in_item.end_of_input,
                                     seq_len:      lead_len(in_item.byte_in)};
        end
    end

endmodule

[rtl/core/u8d_back.sv]
// ---------------------------------------------------------------------------
// u8d_back: decode stage of the UTF-8 decoder
// Keeps the pending bytes, emits at most one code point per step into the result
// register and replays the bytes behind a bad lead.
// ---------------------------------------------------------------------------
module u8d_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  u8d_pkg::q_item_t         q_item,
    input  logic [31:0]              invalid_value,
    output logic                     empty,
    input  logic                     pop,
    output u8d_pkg::out_t            out_item,
    output u8d_pkg::back_status_t    status
);
    import u8d_pkg::*;

    logic [7:0] hold_reg [3];
    logic [2:0] hlen_reg [3];
    logic [1:0] cnt_reg;
    logic       busy_reg;
    logic       last_reg;
    out_t       out_reg, out_next;
    logic       out_valid_reg;

    logic [7:0]  w   [4];
    logic [2:0]  wl  [4];
    logic [7:0]  ws  [4];
    logic [2:0]  wsl [4];
    logic [2:0]  n, len, used, rem, idx;
    logic        lst, can_emit, active, step, hold_all, bad, cont;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [31:0] cp;

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;
    assign status   = '{busy: busy_reg, held: cnt_reg};
    assign can_emit = !out_valid_reg || pop;
    assign active   = busy_reg || q_valid;
    assign step     = active && can_emit;
    assign q_pop    = step && !busy_reg;

    // window: held bytes, plus the queued byte when not replaying
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w[i]  = hold_reg[i];
            wl[i] = hlen_reg[i];
        end
        w[3]  = 8'h00;
        wl[3] = LEN_BAD;
        if (busy_reg)
        begin
            n   = {1'b0, cnt_reg};
            lst = last_reg;
        end
        else
        begin
            w[cnt_reg]  = q_item.byte_in;
            wl[cnt_reg] = q_item.seq_len;
            n           = {1'b0, cnt_reg} + 3'd1;
            lst         = q_item.end_of_input;
        end
    end

    assign len      = wl[0];
    assign hold_all = (len != LEN_BAD) && (len > n) && !lst;

    assign cp2 = {w[0][4:0], w[1][5:0]};
    assign cp3 = {w[0][3:0], w[1][5:0], w[2][5:0]};
    assign cp4 = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};

    always_comb
    begin
        bad = 1'b0;
        cp  = {24'h0, w[0]};
        if ((len == LEN_BAD) || (len > n))
        begin
            bad = 1'b1;
        end
        else
        begin
            case (len)
                LEN_TWO:
                begin
                    cp  = {21'h0, cp2};
                    bad = (cp2 < 11'h080);
                end
                LEN_THREE:
                begin
                    cp  = {16'h0, cp3};
                    bad = (cp3 < 16'h0800) || ((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
                end
                LEN_FOUR:
                begin
                    cp  = {11'h0, cp4};
                    bad = (cp4 < 21'h01_0000) || (cp4 > 21'h10_FFFF);
                end
                default:
                begin
                    cp  = {24'h0, w[0]};
                    bad = 1'b0;
                end
            endcase
        end
    end

    assign used = bad ? LEN_ONE : len;
    assign rem  = n - used;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            idx    = 3'(i) + used;
            ws[i]  = idx[2] ? 8'h00 : w[idx[1:0]];
            wsl[i] = idx[2] ? LEN_BAD : wl[idx[1:0]];
        end
    end

    // another result follows unless nothing is left, or the next lead needs more bytes than are left and input goes on
    assign cont = (rem != 3'd0) && !((wsl[0] != LEN_BAD) && (wsl[0] > rem) && !lst);

    always_comb
    begin
        out_next.code_point = bad ? invalid_value : cp;
        out_next.bytes_used = used;
        out_next.is_invalid = bad;
        out_next.run_last   = !cont;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step && hold_all)
            begin
                cnt_reg  <= n[1:0];
                busy_reg <= 1'b0;
                if (pop)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (step)
            begin
                cnt_reg       <= rem[1:0];
                busy_reg      <= cont;
                last_reg      <= lst;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hold_reg[i] <= hold_all ? w[i]  : ws[i];
                hlen_reg[i] <= hold_all ? wl[i] : wsl[i];
            end
            if (!hold_all)
            begin
                out_reg <= out_next;
            end
        end
    end

endmodule

[rtl/core/utf8_stream_decoder.sv]
// ---------------------------------------------------------------------------
// utf8_stream_decoder: UTF-8 byte stream to code point decoder
// Front queue classifies lead bytes, back stage assembles and checks
// sequences and substitutes invalid_value for bad or truncated ones.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            in_item  (byte_in, end_of_input)
//  result    empty / pop            out_item (code_point, bytes_used,
//                                             is_invalid, run_last)
//  config    cfg_valid / cfg_ready  cfg_data (invalid_value)
//
//  One byte per cycle for valid text while results are popped; a byte that
//  completes nothing gives no result. The back stage emits one result per
//  cycle under the same condition and pops no byte during an error replay.
//  The front queue holds QDEPTH bytes, so input keeps flowing for QDEPTH
//  more bytes while the result register waits on pop; then full rises.
//  cfg_ready is always high.
//  Reset clears the queue and the pending byte count and empties the result register;
//  invalid_value returns to 0xFFFD.
// ---------------------------------------------------------------------------
module utf8_stream_decoder #(
    parameter int QDEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  u8d_pkg::in_t      in_item,
    output logic              empty,
    input  logic              pop,
    output u8d_pkg::out_t     out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import u8d_pkg::*;

    logic         q_valid, q_pop;
    q_item_t      q_item;
    logic [31:0]  invalid_reg;
    back_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_reg <= INVALID_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            invalid_reg <= cfg_data;
        end
    end

    u8d_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_item  (q_item)
    );

    u8d_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .invalid_value (invalid_reg),
        .empty         (empty),
        .pop           (pop),
        .out_item      (out_item),
        .status        (status)
    );

    // a replay always has bytes left to decode
    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> (status.held != 2'd0))
        else $error("replay active with no pending bytes");

    // a substitute consumes exactly one byte
    a_invalid_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.is_invalid) |-> (out_item.bytes_used == 3'd1))
        else $error("invalid result consumed more than one byte");

    // decoded values are Unicode scalar values
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.is_invalid) |-> ((out_item.code_point <= 32'h0010_FFFF)
            && !((out_item.code_point >= 32'h0000_D800)
            && (out_item.code_point <= 32'h0000_DFFF))))
        else $error("decoded value outside scalar range");

    // the queue is only drained when the back stage is not replaying
    a_no_pop_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !q_pop)
        else $error("queue popped during replay");

endmodule
